// ===== hdl/dara_pkg.sv =====
// ----------------------------------------------------------------------------
// dara_pkg
// Shared types and constants of the difference array range store.
// ----------------------------------------------------------------------------
package dara_pkg;

  // Function codes carried on the input side band.
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ADD  = 2'd1;
  localparam logic [1:0] FUNC_SUM  = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Field widths.
  localparam int IDX_W = 8;
  localparam int VAL_W = 32;
  localparam int SUM_W = 48;
  localparam int LEN_W = 9;

  // Reset value of the length register.
  localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_ADD_WR2,
    ST_SUM_RD,
    ST_SUM_DRAIN,
    ST_RESP
  } state_e;

  // Request to the shared add/subtract unit.
  typedef struct packed {
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

// ===== hdl/dara_alu.sv =====
// ----------------------------------------------------------------------------
// dara_alu
// Shared 32-bit add/subtract unit used by load, range add and the sum walk.
// ----------------------------------------------------------------------------
module dara_alu (
  input  dara_pkg::alu_req_t              req_i,
  output logic [dara_pkg::VAL_W-1:0]      y_o
);

  // Elements wrap modulo 2^32, so a plain adder is all that is needed.
  always_comb begin
    if (req_i.sub) begin
      y_o = req_i.a - req_i.b;
    end else begin
      y_o = req_i.a + req_i.b;
    end
  end

endmodule

// ===== hdl/dara_store.sv =====
// ----------------------------------------------------------------------------
// dara_store
// Difference store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module dara_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [dara_pkg::VAL_W-1:0]    wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [dara_pkg::VAL_W-1:0]    rdata_o
);

  logic [dara_pkg::VAL_W-1:0] mem_q [DEPTH];
  logic [dara_pkg::VAL_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dara_seq.sv =====
// ----------------------------------------------------------------------------
// dara_seq
// Sequencer: decodes a word, drives the store and the shared adder, walks
// the store for range sums and holds the result register.
// ----------------------------------------------------------------------------
module dara_seq #(
  parameter int AW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [dara_pkg::IDX_W-1:0]    first_i,
  input  logic [dara_pkg::IDX_W-1:0]    last_i,
  input  logic [dara_pkg::VAL_W-1:0]    value_i,
  // Effective length
  input  logic [dara_pkg::LEN_W-1:0]    len_i,
  // Result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dara_pkg::SUM_W-1:0]    out_sum_o,
  output logic                          out_status_o,
  // Store
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [dara_pkg::VAL_W-1:0]    mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [dara_pkg::VAL_W-1:0]    mem_rdata_i,
  // Shared adder
  output dara_pkg::alu_req_t            alu_req_o,
  input  logic [dara_pkg::VAL_W-1:0]    alu_y_i
);

  dara_pkg::state_e state_q, state_d;

  logic [1:0]                 func_q;
  logic [dara_pkg::IDX_W-1:0] lo_q, hi_q, cnt_q, ridx_q;
  logic [dara_pkg::VAL_W-1:0] val_q, prev_q, elem_q;
  logic [dara_pkg::SUM_W-1:0] sum_q, out_sum_q;
  logic                       rvld_q, eacc_q, err_q, err_d;
  logic                       out_vld_q, out_status_q;
  logic                       range_ok, load_ok, tail_ok, out_free;
  logic [dara_pkg::LEN_W-1:0] hi_plus;

  // Index checks against the effective length.
  assign hi_plus  = {1'b0, hi_q} + 9'd1;
  assign range_ok = (lo_q <= hi_q) && ({1'b0, hi_q} < len_i);
  assign load_ok  = {1'b0, lo_q} < len_i;
  assign tail_ok  = hi_plus < len_i;
  assign out_free = !out_vld_q || out_ready_i;

  // Error decision for the current word.
  always_comb begin
    case (func_q)
      dara_pkg::FUNC_LOAD: err_d = !load_ok;
      dara_pkg::FUNC_ADD:  err_d = !range_ok;
      dara_pkg::FUNC_SUM:  err_d = !range_ok;
      default:             err_d = dara_pkg::STATUS_ERR;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dara_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = dara_pkg::ST_DISPATCH;
      end
      dara_pkg::ST_DISPATCH: begin
        if (err_d) begin
          state_d = dara_pkg::ST_RESP;
        end else if (func_q == dara_pkg::FUNC_ADD) begin
          state_d = dara_pkg::ST_ADD_RD;
        end else if (func_q == dara_pkg::FUNC_SUM) begin
          state_d = dara_pkg::ST_SUM_RD;
        end else begin
          state_d = dara_pkg::ST_RESP;
        end
      end
      dara_pkg::ST_ADD_RD:  state_d = dara_pkg::ST_ADD_WR;
      dara_pkg::ST_ADD_WR: begin
        state_d = tail_ok ? dara_pkg::ST_ADD_WR2 : dara_pkg::ST_RESP;
      end
      dara_pkg::ST_ADD_WR2: state_d = dara_pkg::ST_RESP;
      dara_pkg::ST_SUM_RD: begin
        if (cnt_q == hi_q) state_d = dara_pkg::ST_SUM_DRAIN;
      end
      dara_pkg::ST_SUM_DRAIN: begin
        if (!rvld_q && !eacc_q) state_d = dara_pkg::ST_RESP;
      end
      dara_pkg::ST_RESP: begin
        if (out_free) state_d = dara_pkg::ST_IDLE;
      end
      default: state_d = dara_pkg::ST_IDLE;
    endcase
  end

  // Store and adder control.
  always_comb begin
    in_ready_o      = 1'b0;
    mem_we_o        = 1'b0;
    mem_waddr_o     = AW'(lo_q);
    mem_wdata_o     = alu_y_i;
    mem_raddr_o     = AW'(lo_q);
    alu_req_o.a     = elem_q;
    alu_req_o.b     = mem_rdata_i;
    alu_req_o.sub   = 1'b0;
    case (state_q)
      dara_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      dara_pkg::ST_DISPATCH: begin
        // A load stores the step from the previously loaded value, or the value itself at index zero.
        alu_req_o.a   = val_q;
        alu_req_o.b   = prev_q;
        alu_req_o.sub = 1'b1;
        if (func_q == dara_pkg::FUNC_LOAD && load_ok) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = (lo_q == '0) ? val_q : alu_y_i;
        end
      end
      dara_pkg::ST_ADD_WR: begin
        // Add at the first index, fetch the entry past the range.
        alu_req_o.a = mem_rdata_i;
        alu_req_o.b = val_q;
        mem_we_o    = 1'b1;
        mem_raddr_o = AW'(hi_plus);
      end
      dara_pkg::ST_ADD_WR2: begin
        alu_req_o.a   = mem_rdata_i;
        alu_req_o.b   = val_q;
        alu_req_o.sub = 1'b1;
        mem_we_o      = 1'b1;
        mem_waddr_o   = AW'(hi_plus);
      end
      dara_pkg::ST_SUM_RD: begin
        mem_raddr_o = AW'(cnt_q);
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dara_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture of the accepted word.
  always_ff @(posedge clk_i) begin
    if (state_q == dara_pkg::ST_IDLE && in_valid_i) begin
      func_q <= func_i;
      lo_q   <= first_i;
      hi_q   <= last_i;
      val_q  <= value_i;
    end
  end

  // Previously loaded value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (state_q == dara_pkg::ST_DISPATCH && func_q == dara_pkg::FUNC_LOAD
                 && load_ok) begin
      prev_q <= val_q;
    end
  end

  // Sum walk pipeline: read, rebuild element, accumulate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
      eacc_q <= 1'b0;
    end else begin
      rvld_q <= (state_q == dara_pkg::ST_SUM_RD);
      eacc_q <= rvld_q && (ridx_q >= lo_q);
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= cnt_q;
    if (state_q == dara_pkg::ST_DISPATCH) begin
      cnt_q  <= '0;
      elem_q <= '0;
      sum_q  <= '0;
      err_q  <= err_d;
    end else begin
      if (state_q == dara_pkg::ST_SUM_RD) cnt_q <= cnt_q + 8'd1;
      if (rvld_q) elem_q <= alu_y_i;
      if (eacc_q) sum_q <= sum_q + {{(dara_pkg::SUM_W - dara_pkg::VAL_W){elem_q[31]}},
                                    elem_q};
    end
  end

  // Result register; the sum stays zero for every word but a good query.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == dara_pkg::ST_RESP && out_free) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dara_pkg::ST_RESP && out_free) begin
      out_sum_q    <= sum_q;
      out_status_q <= err_q ? dara_pkg::STATUS_ERR : dara_pkg::STATUS_OK;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_sum_o    = out_sum_q;
  assign out_status_o = out_status_q;

endmodule

// ===== hdl/difference_array_range_add_sum.sv =====
// A load writes its step at dispatch; a range add updates the entry at first_index
// and the entry past last_index if that index is below the length; a range sum walks
// the store from index zero to last_index at one read per cycle through the single
// read port and the shared adder. One word is in work at a time; the input is ready
// again once the result is in the output register.
// Reset (rst_ni, async, active low) sets length to 256 and clears the control.
// ----------------------------------------------------------------------------
// difference_array_range_add_sum
// Difference array store with range add and range sum, APB length register.
// ----------------------------------------------------------------------------
module difference_array_range_add_sum #(
  parameter int DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // first_index[7:0], last_index[15:8], value[47:16]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // range_sum[47:0]
  output logic [0:0]  m_axis_tuser,   // status[0]
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [dara_pkg::LEN_W-1:0] LEN_CAP =
    (DEPTH < 511) ? dara_pkg::LEN_W'(DEPTH) : 9'd511;

  logic [dara_pkg::LEN_W-1:0] length_q, len_eff;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [dara_pkg::VAL_W-1:0] mem_wdata, mem_rdata, alu_y;
  dara_pkg::alu_req_t         alu_req;
  logic                       out_status;

  // Length register, written by an access-phase write to register zero.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= dara_pkg::LEN_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      length_q <= pwdata[dara_pkg::LEN_W-1:0];
    end
  end

  assign prdata  = paddr[2] ? 32'd0 : {23'd0, length_q};
  assign len_eff = (length_q > LEN_CAP) ? LEN_CAP : length_q;

  dara_seq #(.AW(AW)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .func_i       (s_axis_tuser),
    .first_i      (s_axis_tdata[7:0]),
    .last_i       (s_axis_tdata[15:8]),
    .value_i      (s_axis_tdata[47:16]),
    .len_i        (len_eff),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sum_o    (m_axis_tdata),
    .out_status_o (out_status),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .alu_req_o    (alu_req),
    .alu_y_i      (alu_y)
  );

  assign m_axis_tuser = out_status;

  dara_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dara_alu u_alu (
    .req_i (alu_req),
    .y_o   (alu_y)
  );

endmodule

// ===== hdl/dara_chk.sv =====
// ----------------------------------------------------------------------------
// dara_chk
// Port-level checks of the difference array range store.
// ----------------------------------------------------------------------------
module dara_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // The block works on one word at a time, so it is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after an accepted word");

  // A stalled result holds its data.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // An error result carries a zero sum.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 48'd0))
    else $error("error result with nonzero sum");

  // No result is shown while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind difference_array_range_add_sum dara_chk u_chk (.*);
